>>> sv/msmo_pkg.sv
// Shared widths, record type and register codes for the slice mean/std unit.
`timescale 1ns / 1ps
package msmo_pkg;

	localparam int SAMPLE_BITS       = 16;
	localparam int MAX_SLICE_SAMPLES = 1048576;

	// Count, sum and sum-of-squares widths that cannot wrap within one slice
	localparam int N_W   = $clog2(MAX_SLICE_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_BITS + N_W;
	localparam int MAG_W = SUM_W - 1;
	localparam int SQ_W  = 2 * SAMPLE_BITS - 2 + N_W;

	// Back-end arithmetic widths
	localparam int PROD_W    = N_W + SQ_W;
	localparam int DEN_W     = 2 * N_W;
	localparam int REM_W     = DEN_W + 1;
	localparam int FRAC_BITS = 16;
	localparam int STD_SHIFT = 32;
	localparam int DIVD_W    = PROD_W + STD_SHIFT;
	localparam int QUO_W     = 64;
	localparam int OUT_W     = 32;
	localparam int STEP_W    = $clog2(DIVD_W + 1);

	// Configuration registers
	localparam int LEN_W      = 21;
	localparam int CNT_W      = 16;
	localparam int CFG_DATA_W = 21;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_SLICE_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT  = 1'b1;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);

	// Queue between accumulator and statistics engine
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// One finished slice
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [SQ_W-1:0]         sq;
		logic [N_W-1:0]          n;
		logic                    last;
	} rec_t;

endpackage

>>> sv/msmo_ifs.sv
// Handshake channel interfaces: sample input, result output, configuration.
`timescale 1ns / 1ps
interface msmo_in_if;
	logic                                        valid;
	logic                                        ready;
	logic signed [msmo_pkg::SAMPLE_BITS-1:0]     sample;
	logic                                        missing;
	modport source (output valid, sample, missing, input ready);
	modport sink (input valid, sample, missing, output ready);
endinterface

interface msmo_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [msmo_pkg::OUT_W-1:0] mean_value;
	logic [msmo_pkg::OUT_W-1:0]        std_value;
	logic                              stats_valid;
	logic                              last_slice;
	modport source (output valid, mean_value, std_value, stats_valid, last_slice, input ready);
	modport sink (input valid, mean_value, std_value, stats_valid, last_slice, output ready);
endinterface

interface msmo_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [msmo_pkg::CFG_IDX_W-1:0]     index;
	logic [msmo_pkg::CFG_DATA_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/slice_mean_std_omit_missing_unit.sv
// Top level of the per-slice mean and standard deviation unit.
//
//  channel | dir | words                         | accepted when
//  in_ch   | in  | sample, missing               | in_ch.valid && in_ch.ready
//  out_ch  | out | mean_value, std_value, flags  | out_ch.valid && out_ch.ready
//  cfg     | in  | index, data                   | cfg.valid (ready held high)
//
// Samples enter one per cycle while the four-entry record queue has room.
// Each slice end hands one record to the back end (serial multiplier, restoring
// divider, root loop), which takes no new record until its result is loaded;
// fewer than two present samples skip straight to the result.
// The result register lets the back end finish while the sink stalls.
// Reset clears all sums, counters and the queue; no clearing pass is needed.
`timescale 1ns / 1ps
module slice_mean_std_omit_missing_unit (
	input  logic        clk,
	input  logic        arst_n,
	msmo_in_if.sink     in_ch,
	msmo_out_if.source  out_ch,
	msmo_cfg_if.sink    cfg
);

	logic           push;
	logic           not_full;
	logic           pop;
	logic           not_empty;
	msmo_pkg::rec_t push_rec;
	msmo_pkg::rec_t pop_rec;

	msmo_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.cfg     (cfg),
		.q_ready (not_full),
		.q_push  (push),
		.q_rec   (push_rec)
	);

	msmo_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.not_full  (not_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_rec   (pop_rec)
	);

	msmo_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_rec   (pop_rec),
		.q_pop   (pop),
		.out_ch  (out_ch)
	);

endmodule

>>> sv/msmo_front.sv
// Front end: configuration registers and per-sample accumulation over a slice.
`timescale 1ns / 1ps
module msmo_front (
	input  logic            clk,
	input  logic            arst_n,
	msmo_in_if.sink         in_ch,
	msmo_cfg_if.sink        cfg,
	input  logic            q_ready,
	output logic            q_push,
	output msmo_pkg::rec_t  q_rec
);

	localparam int EXT_W = msmo_pkg::LEN_W + msmo_pkg::N_W;

	logic [msmo_pkg::LEN_W-1:0]        len_q;
	logic [msmo_pkg::CNT_W-1:0]        cnt_q;
	logic signed [msmo_pkg::SUM_W-1:0] sum_q;
	logic [msmo_pkg::SQ_W-1:0]         sq_q;
	logic [msmo_pkg::N_W-1:0]          n_q;
	logic [msmo_pkg::N_W-1:0]          pos_q;
	logic [msmo_pkg::CNT_W-1:0]        idx_q;

	logic [EXT_W-1:0]                        len_ext;
	logic [msmo_pkg::N_W-1:0]                len_eff;
	logic [msmo_pkg::CNT_W-1:0]              cnt_eff;
	logic [msmo_pkg::N_W:0]                  pos_nx;
	logic [msmo_pkg::CNT_W:0]                idx_nx;
	logic                                    slice_end;
	logic                                    is_last;
	logic                                    acc;
	logic signed [2*msmo_pkg::SAMPLE_BITS-1:0] sq_term;
	logic signed [msmo_pkg::SUM_W-1:0]       sum_nx;
	logic [msmo_pkg::SQ_W-1:0]               sq_nx;
	logic [msmo_pkg::N_W-1:0]                n_nx;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = q_ready;
	assign acc         = in_ch.valid && q_ready;

	// Clamp the slice length to 1..MAX and the slice count to at least 1
	assign len_ext = EXT_W'(len_q);
	always_comb begin
		if (len_q == '0) begin
			len_eff = msmo_pkg::N_W'(1);
		end else if (len_ext > EXT_W'(msmo_pkg::MAX_SLICE_SAMPLES)) begin
			len_eff = msmo_pkg::N_W'(msmo_pkg::MAX_SLICE_SAMPLES);
		end else begin
			len_eff = msmo_pkg::N_W'(len_q);
		end
	end
	assign cnt_eff = (cnt_q == '0) ? msmo_pkg::CNT_W'(1) : cnt_q;

	assign pos_nx    = {1'b0, pos_q} + 1'b1;
	assign slice_end = pos_nx >= {1'b0, len_eff};
	assign idx_nx    = {1'b0, idx_q} + 1'b1;
	assign is_last   = idx_nx >= {1'b0, cnt_eff};

	// Add the sample in unless it is missing
	assign sq_term = in_ch.sample * in_ch.sample;
	always_comb begin
		if (in_ch.missing) begin
			sum_nx = sum_q;
			sq_nx  = sq_q;
			n_nx   = n_q;
		end else begin
			sum_nx = sum_q + msmo_pkg::SUM_W'(in_ch.sample);
			sq_nx  = sq_q + msmo_pkg::SQ_W'($unsigned(sq_term));
			n_nx   = n_q + 1'b1;
		end
	end

	assign q_push      = acc && slice_end;
	assign q_rec.sum   = sum_nx;
	assign q_rec.sq    = sq_nx;
	assign q_rec.n     = n_nx;
	assign q_rec.last  = is_last;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= msmo_pkg::LEN_RESET;
			cnt_q <= msmo_pkg::CNT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				msmo_pkg::REG_SLICE_LENGTH: len_q <= msmo_pkg::LEN_W'(cfg.data);
				msmo_pkg::REG_SLICE_COUNT:  cnt_q <= msmo_pkg::CNT_W'(cfg.data);
				default: ;
			endcase
		end
	end

	// Accumulate, and clear at the end of each slice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q  <= '0;
			n_q   <= '0;
			pos_q <= '0;
			idx_q <= '0;
		end else if (acc) begin
			if (slice_end) begin
				sum_q <= '0;
				sq_q  <= '0;
				n_q   <= '0;
				pos_q <= '0;
				idx_q <= is_last ? '0 : idx_nx[msmo_pkg::CNT_W-1:0];
			end else begin
				sum_q <= sum_nx;
				sq_q  <= sq_nx;
				n_q   <= n_nx;
				pos_q <= pos_nx[msmo_pkg::N_W-1:0];
			end
		end
	end

endmodule

>>> sv/msmo_queue.sv
// Short queue of finished slice records between front and back ends.
`timescale 1ns / 1ps
module msmo_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  msmo_pkg::rec_t  push_rec,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output msmo_pkg::rec_t  pop_rec
);

	msmo_pkg::rec_t                mem_q [msmo_pkg::QDEPTH];
	logic [msmo_pkg::QPTR_W-1:0]   wr_q;
	logic [msmo_pkg::QPTR_W-1:0]   rd_q;
	logic [msmo_pkg::QPTR_W:0]     fill_q;

	assign not_full  = fill_q != (msmo_pkg::QPTR_W+1)'(msmo_pkg::QDEPTH);
	assign not_empty = fill_q != '0;
	assign pop_rec   = mem_q[rd_q];

	// Store pushed records
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			fill_q <= fill_q + (msmo_pkg::QPTR_W+1)'(push) - (msmo_pkg::QPTR_W+1)'(pop);
		end
	end

endmodule

>>> sv/msmo_back.sv
// Back end: serial multiplies, long divisions and square root per slice record.
`timescale 1ns / 1ps
module msmo_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  msmo_pkg::rec_t  q_rec,
	output logic            q_pop,
	msmo_out_if.source      out_ch
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIVM = 6'b000100,
		ST_DIVS = 6'b001000,
		ST_SQRT = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	localparam logic [1:0] PH_NSQ = 2'd0;  // n * sum of squares
	localparam logic [1:0] PH_SS  = 2'd1;  // |sum| * |sum|
	localparam logic [1:0] PH_DEN = 2'd2;  // n * (n - 1)

	state_t state_q;
	logic [1:0]                  ph_q;
	logic [msmo_pkg::STEP_W-1:0] step_q;

	// Slice operands
	logic [msmo_pkg::MAG_W-1:0]  smag_q;
	logic                        neg_q;
	logic [msmo_pkg::N_W-1:0]    n_q;
	logic                        last_q;
	logic [msmo_pkg::PROD_W-1:0] a_q;
	logic [msmo_pkg::PROD_W-1:0] b_q;
	logic [msmo_pkg::DEN_W-1:0]  den_q;

	// Shift-add multiplier
	logic [msmo_pkg::PROD_W-1:0] mc_q;
	logic [msmo_pkg::MAG_W-1:0]  mp_q;
	logic [msmo_pkg::PROD_W-1:0] prod_q;
	logic [msmo_pkg::PROD_W-1:0] prod_nx;
	logic                        mul_last;

	// Restoring divider
	logic [msmo_pkg::DIVD_W-1:0] divd_q;
	logic [msmo_pkg::DEN_W-1:0]  dvs_q;
	logic [msmo_pkg::REM_W-1:0]  rem_q;
	logic [msmo_pkg::QUO_W-1:0]  quo_q;
	logic                        ovf_q;
	logic [msmo_pkg::REM_W-1:0]  rem_sh;
	logic                        rem_ge;
	logic [msmo_pkg::QUO_W-1:0]  quo_nx;
	logic                        ovf_nx;
	logic                        div_last;

	// Bitwise square root
	logic [msmo_pkg::QUO_W-1:0]  x_q;
	logic [msmo_pkg::OUT_W-1:0]  root_q;
	logic [msmo_pkg::OUT_W-1:0]  sbit_q;
	logic [msmo_pkg::OUT_W-1:0]  trial;
	logic [msmo_pkg::QUO_W-1:0]  trial_sq;

	// Results and output register
	logic signed [msmo_pkg::OUT_W-1:0] mean_q;
	logic [msmo_pkg::OUT_W-1:0]        std_q;
	logic                              valid_q;
	logic                              out_v_q;
	logic                              out_load;

	logic [msmo_pkg::MAG_W-1:0]  rec_mag;
	logic                        rec_few;
	logic [msmo_pkg::OUT_W-1:0]  q32;
	logic [msmo_pkg::PROD_W-1:0] num;

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign rec_mag  = msmo_pkg::MAG_W'($unsigned(q_rec.sum[msmo_pkg::SUM_W-1] ?
		-q_rec.sum : q_rec.sum));
	assign rec_few  = q_rec.n < msmo_pkg::N_W'(2);

	assign prod_nx  = prod_q + (mp_q[0] ? mc_q : '0);
	assign mul_last = step_q == msmo_pkg::STEP_W'(msmo_pkg::MAG_W - 1);

	assign rem_sh   = {rem_q[msmo_pkg::REM_W-2:0], divd_q[msmo_pkg::DIVD_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, dvs_q};
	assign quo_nx   = {quo_q[msmo_pkg::QUO_W-2:0], rem_ge};
	assign ovf_nx   = ovf_q | quo_q[msmo_pkg::QUO_W-1];
	assign div_last = step_q == msmo_pkg::STEP_W'(msmo_pkg::DIVD_W - 1);

	assign trial    = root_q | sbit_q;
	assign trial_sq = trial * trial;

	assign q32      = quo_nx[msmo_pkg::OUT_W-1:0];
	assign num      = (a_q >= b_q) ? a_q - b_q : '0;

	assign out_load = (state_q == ST_DONE) && (!out_v_q || out_ch.ready);

	// Sequence the record through the arithmetic units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= PH_NSQ;
			step_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= rec_few ? ST_DONE : ST_MUL;
						ph_q    <= PH_NSQ;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (mul_last) begin
						step_q <= '0;
						if (ph_q == PH_DEN) begin
							state_q <= ST_DIVM;
						end else begin
							ph_q <= ph_q + 1'b1;
						end
					end
				end
				ST_DIVM: begin
					step_q <= div_last ? '0 : step_q + 1'b1;
					if (div_last) begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					step_q <= div_last ? '0 : step_q + 1'b1;
					if (div_last) begin
						state_q <= ovf_nx ? ST_DONE : ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sbit_q[0]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				smag_q  <= rec_mag;
				neg_q   <= q_rec.sum[msmo_pkg::SUM_W-1];
				n_q     <= q_rec.n;
				last_q  <= q_rec.last;
				valid_q <= !rec_few;
				mean_q  <= '0;
				std_q   <= '0;
				mc_q    <= msmo_pkg::PROD_W'(q_rec.sq);
				mp_q    <= msmo_pkg::MAG_W'(q_rec.n);
				prod_q  <= '0;
			end
			ST_MUL: begin
				prod_q <= prod_nx;
				mc_q   <= mc_q << 1;
				mp_q   <= mp_q >> 1;
				if (mul_last) begin
					prod_q <= '0;
					unique case (ph_q)
						PH_NSQ: begin
							a_q  <= prod_nx;
							mc_q <= msmo_pkg::PROD_W'(smag_q);
							mp_q <= smag_q;
						end
						PH_SS: begin
							b_q  <= prod_nx;
							mc_q <= msmo_pkg::PROD_W'(n_q);
							mp_q <= msmo_pkg::MAG_W'(n_q - 1'b1);
						end
						default: begin
							den_q  <= msmo_pkg::DEN_W'(prod_nx);
							divd_q <= msmo_pkg::DIVD_W'(smag_q) << msmo_pkg::FRAC_BITS;
							dvs_q  <= msmo_pkg::DEN_W'(n_q);
							rem_q  <= '0;
							quo_q  <= '0;
							ovf_q  <= 1'b0;
						end
					endcase
				end
			end
			ST_DIVM, ST_DIVS: begin
				divd_q <= divd_q << 1;
				rem_q  <= rem_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
				quo_q  <= quo_nx;
				ovf_q  <= ovf_nx;
				if (div_last && state_q == ST_DIVM) begin
					mean_q <= neg_q ? -q32 : q32;
					divd_q <= msmo_pkg::DIVD_W'(num) << msmo_pkg::STD_SHIFT;
					dvs_q  <= den_q;
					rem_q  <= '0;
					quo_q  <= '0;
					ovf_q  <= 1'b0;
				end
				if (div_last && state_q == ST_DIVS) begin
					x_q    <= quo_nx;
					root_q <= '0;
					sbit_q <= msmo_pkg::OUT_W'(1) << (msmo_pkg::OUT_W - 1);
					std_q  <= '1;
				end
			end
			ST_SQRT: begin
				if (trial_sq <= x_q) begin
					root_q <= trial;
				end
				sbit_q <= sbit_q >> 1;
				if (sbit_q[0]) begin
					std_q <= (trial_sq <= x_q) ? trial : root_q;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_ch.mean_value  <= mean_q;
					out_ch.std_value   <= std_q;
					out_ch.stats_valid <= valid_q;
					out_ch.last_slice  <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid = out_v_q;

endmodule

>>> sv/msmo_checker.sv
// Port-level checks on the slice statistics unit, bound to its top level.
`timescale 1ns / 1ps
module msmo_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [msmo_pkg::OUT_W-1:0]        mean_value,
	input logic [msmo_pkg::OUT_W-1:0]        std_value,
	input logic                              stats_valid,
	input logic                              cfg_ready
);

	// Hold a stalled result word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_value) && $stable(std_value))
		else $error("stalled result changed");

	// Zero statistics on a slice with fewer than two samples
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stats_valid |-> mean_value == '0 && std_value == '0)
		else $error("invalid slice carries nonzero statistics");

	// Take configuration writes at all times
	assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind slice_mean_std_omit_missing_unit msmo_checker u_msmo_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.mean_value  (out_ch.mean_value),
	.std_value   (out_ch.std_value),
	.stats_valid (out_ch.stats_valid),
	.cfg_ready   (cfg.ready)
);
